/* rtl/core/vsb_pkg.sv */
// Shared widths, codes and fixed-point helpers for the Verlet sphere body step unit.
package vsb_pkg;

  localparam int CW = 32;       // coordinate width, signed
  localparam int FB = 16;       // fraction bits
  localparam int RW = CW - 1;   // radius / time step width, unsigned

  localparam logic [2:0] REQ_INTEGRATE = 3'd0;
  localparam logic [2:0] REQ_ADD_FORCE = 3'd1;
  localparam logic [2:0] REQ_COLLIDE   = 3'd2;
  localparam logic [2:0] REQ_MOVE      = 3'd3;
  localparam logic [2:0] REQ_SET_POS   = 3'd4;
  localparam logic [2:0] REQ_PLACE     = 3'd5;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_STEP   = 2'd1;
  localparam logic [1:0] CFG_STATIC = 2'd2;

  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic [2*CW-1:0] P_HALF = {{CW{1'b0}}, 1'b1, {(CW-1){1'b0}}};
  localparam logic [2*CW-1:0] P_MAXC = {{(CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [2*CW-1:0] P_RND  = {{(2*CW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  // saturate a one-bit-grown sum back to coordinate range
  function automatic logic [CW-1:0] sat_c(input logic [CW:0] v);
    if (v[CW] != v[CW-1]) begin
      return v[CW] ? C_MIN : C_MAX;
    end
    return v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] add_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return sat_c({a[CW-1], a} + {b[CW-1], b});
  endfunction

  function automatic logic [CW-1:0] sub_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return sat_c({a[CW-1], a} - {b[CW-1], b});
  endfunction

  // round magnitude product half away from zero, drop fraction, apply sign, saturate
  function automatic logic [CW-1:0] mulq_fix(input logic [2*CW-1:0] p, input logic neg);
    logic [2*CW-1:0] m;
    m = (p + P_RND) >> FB;
    if (neg) begin
      return (m > P_HALF) ? C_MIN : (~m[CW-1:0] + 1'b1);
    end
    return (m > P_MAXC) ? C_MAX : m[CW-1:0];
  endfunction

endpackage

/* rtl/core/vsb_mul.sv */
// Bit-serial shift-add multiplier, unsigned CW x CW, one multiplier bit per cycle.
module vsb_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vsb_pkg::CW-1:0]    a,
  input  logic [vsb_pkg::CW-1:0]    b,
  output logic                      done,
  output logic [2*vsb_pkg::CW-1:0]  p
);

  localparam int CNT_W = $clog2(vsb_pkg::CW + 1);

  logic [vsb_pkg::CW-1:0] mc_r, mc_nxt;
  logic [vsb_pkg::CW-1:0] hi_r, hi_nxt;
  logic [vsb_pkg::CW-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [vsb_pkg::CW:0]   psum;

  always_comb begin
    psum     = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);
    mc_nxt   = mc_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mc_nxt   = a;
      hi_nxt   = '0;
      lo_nxt   = b;
      cnt_nxt  = CNT_W'(vsb_pkg::CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = psum[vsb_pkg::CW:1];
      lo_nxt  = {psum[0], lo_r[vsb_pkg::CW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r <= mc_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done = done_r;
  assign p    = {hi_r, lo_r};

endmodule

/* rtl/core/vsb_sqrt.sv */
// Restoring integer square root, two radicand bits per cycle, one root bit out.
module vsb_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [2*vsb_pkg::CW-1:0]  x,
  output logic                      done,
  output logic [vsb_pkg::CW-1:0]    root
);

  localparam int CW    = vsb_pkg::CW;
  localparam int CNT_W = $clog2(CW + 1);

  logic [2*CW-1:0]  x_r, x_nxt;
  logic [CW+1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW+3:0]    rem_t, trial, diff;
  logic             ge;

  always_comb begin
    rem_t    = {rem_r, x_r[2*CW-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = rem_t >= trial;
    diff     = rem_t - trial;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = {x_r[2*CW-3:0], 2'b00};
      rem_nxt  = ge ? diff[CW+1:0] : rem_t[CW+1:0];
      root_nxt = {root_r[CW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/core/vsb_div.sv */
// Restoring divider, one quotient bit per cycle; low CW quotient bits kept.
module vsb_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [2*vsb_pkg::CW-1:0]  num,
  input  logic [vsb_pkg::CW:0]      den,
  output logic                      done,
  output logic [vsb_pkg::CW-1:0]    quo
);

  localparam int CW    = vsb_pkg::CW;
  localparam int CNT_W = $clog2(2*CW + 1);

  logic [2*CW-1:0]  n_r, n_nxt;
  logic [CW:0]      d_r, d_nxt;
  logic [CW:0]      rem_r, rem_nxt;
  logic [CW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW+1:0]    rt, diff;
  logic             ge;

  always_comb begin
    rt       = {rem_r, n_r[2*CW-1]};
    ge       = rt >= {1'b0, d_r};
    diff     = rt - {1'b0, d_r};
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = num;
      d_nxt    = den;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(2*CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt   = {n_r[2*CW-2:0], 1'b0};
      rem_nxt = ge ? diff[CW:0] : rt[CW:0];
      q_nxt   = {q_r[CW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* rtl/core/verlet_sphere_body_step_unit.sv */
// Top level: sphere body state, request sequencer and serial arithmetic units.
//
// One sphere body under position Verlet integration, signed Q16.16.
// Input channel (in_valid/in_ready) carries one request word: req_type,
// vec_x/y/z and other_radius. Every request gives exactly one result word on
// the output channel (out_valid/out_ready): the current position, the shift
// for the other sphere and the contact flag.
// Config channel (cfg_valid/cfg_ready, always ready) writes body_radius,
// step_time and body_static by index; write only while the block is idle.
// Move, set position, place, add force, static and unused codes go from
// dispatch straight to the result. Integrate runs one serial multiply for
// dt*dt, then per axis one multiply plus three update steps. Collide runs
// three squares, the squared radius sum, a square root and per axis a
// multiply and a divide; a miss on one axis ends right after the difference
// step. The bit-serial multiplier, root and divide units are shared; one item
// is in work at a time.
// Reset clears the positions and acceleration and loads the default config.
// The result sits in an output register; a new word is taken while it waits,
// and the sequencer holds its next result until the register is freed.
module verlet_sphere_body_step_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_req_type,
  input  logic signed [vsb_pkg::CW-1:0] in_vec_x,
  input  logic signed [vsb_pkg::CW-1:0] in_vec_y,
  input  logic signed [vsb_pkg::CW-1:0] in_vec_z,
  input  logic [vsb_pkg::RW-1:0]        in_other_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [vsb_pkg::CW-1:0] out_pos_x,
  output logic signed [vsb_pkg::CW-1:0] out_pos_y,
  output logic signed [vsb_pkg::CW-1:0] out_pos_z,
  output logic signed [vsb_pkg::CW-1:0] out_other_shift_x,
  output logic signed [vsb_pkg::CW-1:0] out_other_shift_y,
  output logic signed [vsb_pkg::CW-1:0] out_other_shift_z,
  output logic                          out_contact,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [vsb_pkg::RW-1:0]        cfg_data
);

  localparam int CW = vsb_pkg::CW;
  localparam int RW = vsb_pkg::RW;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_DT2   = 5'd2;
  localparam logic [4:0] S_ACCS  = 5'd3;
  localparam logic [4:0] S_ACCM  = 5'd4;
  localparam logic [4:0] S_VEL   = 5'd5;
  localparam logic [4:0] S_UPD   = 5'd6;
  localparam logic [4:0] S_CDIFF = 5'd7;
  localparam logic [4:0] S_SQS   = 5'd8;
  localparam logic [4:0] S_SQ    = 5'd9;
  localparam logic [4:0] S_RSQS  = 5'd10;
  localparam logic [4:0] S_RSQ   = 5'd11;
  localparam logic [4:0] S_SQRTS = 5'd12;
  localparam logic [4:0] S_SQRT  = 5'd13;
  localparam logic [4:0] S_CMS   = 5'd14;
  localparam logic [4:0] S_CMUL  = 5'd15;
  localparam logic [4:0] S_CDIV  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  localparam logic [1:0] AX_LAST = 2'd2;

  // body state
  logic [CW-1:0] cur_r [0:2], cur_nxt [0:2];
  logic [CW-1:0] prev_r [0:2], prev_nxt [0:2];
  logic [CW-1:0] acc_r [0:2], acc_nxt [0:2];
  logic [RW-1:0] radius_r, radius_nxt;
  logic [RW-1:0] dt_r, dt_nxt;
  logic          static_r, static_nxt;

  // sequencer control
  logic [4:0] st_r, st_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       out_valid_r, out_valid_nxt;

  // latched request
  logic [2:0]    req_r;
  logic [CW-1:0] vec_r [0:2];
  logic [RW-1:0] orad_r;

  // work registers
  logic [CW-1:0]     dt2_r, dt2_nxt;
  logic [CW-1:0]     term_r, term_nxt;
  logic [CW-1:0]     inc_r, inc_nxt;
  logic [CW-1:0]     rsum_r, rsum_nxt;
  logic [CW-1:0]     ad_r [0:2], ad_nxt [0:2];
  logic [2:0]        neg_r, neg_nxt;
  logic [2*CW+1:0]   sum_r, sum_nxt;
  logic [CW-1:0]     dist_r, dist_nxt;
  logic [CW-1:0]     delta_r, delta_nxt;
  logic [CW-1:0]     sh_r [0:2], sh_nxt [0:2];
  logic              contact_r, contact_nxt;

  // output register
  logic [CW-1:0] opos_r [0:2];
  logic [CW-1:0] osh_r [0:2];
  logic          ocon_r;
  logic          out_load;

  // arithmetic unit hookup
  logic            mul_start, mul_done;
  logic [CW-1:0]   mul_a, mul_b;
  logic [2*CW-1:0] mul_p;
  logic            sqrt_start, sqrt_done;
  logic [CW-1:0]   sqrt_root;
  logic            div_start, div_done;
  logic [CW-1:0]   div_quo;

  // collide distance terms, three axes side by side
  logic [CW:0]   cd [0:2];
  logic [CW:0]   cad [0:2];
  logic          far;
  logic [CW-1:0] rsum_w;
  logic [CW-1:0] cur_ax, acc_ax, q_signed;
  logic          do_int, do_add, do_col;

  vsb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  vsb_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (sum_r[2*CW-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  vsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_p + {{CW{1'b0}}, dist_r}),
    .den   ({dist_r, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign rsum_w = {1'b0, radius_r} + {1'b0, orad_r};
  assign cur_ax = cur_r[ax_r];
  assign acc_ax = acc_r[ax_r];
  assign q_signed = neg_r[ax_r] ? (~div_quo + 1'b1) : div_quo;

  assign do_int = (req_r == vsb_pkg::REQ_INTEGRATE) && !static_r;
  assign do_add = (req_r == vsb_pkg::REQ_ADD_FORCE) && !static_r;
  assign do_col = (req_r == vsb_pkg::REQ_COLLIDE) && !static_r;

  always_comb begin
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cd[i]  = {cur_r[i][CW-1], cur_r[i]} - {vec_r[i][CW-1], vec_r[i]};
      cad[i] = cd[i][CW] ? (~cd[i] + 1'b1) : cd[i];
      if (cad[i] >= {1'b0, rsum_w}) begin
        far = 1'b1;
      end
    end
  end

  // unit launches and operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (st_r)
      S_DISP: begin
        mul_start = do_int;
        mul_a     = {1'b0, dt_r};
        mul_b     = {1'b0, dt_r};
      end
      S_ACCS: begin
        mul_start = 1'b1;
        mul_a     = acc_ax[CW-1] ? (~acc_ax + 1'b1) : acc_ax;
        mul_b     = dt2_r;
      end
      S_SQS: begin
        mul_start = 1'b1;
        mul_a     = ad_r[ax_r];
        mul_b     = ad_r[ax_r];
      end
      S_RSQS: begin
        mul_start = 1'b1;
        mul_a     = rsum_r;
        mul_b     = rsum_r;
      end
      S_CMS: begin
        mul_start = 1'b1;
        mul_a     = ad_r[ax_r];
        mul_b     = delta_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (st_r == S_SQRTS);
  assign div_start  = (st_r == S_CMUL) && mul_done;

  assign out_load = (st_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt        = st_r;
    ax_nxt        = ax_r;
    radius_nxt    = radius_r;
    dt_nxt        = dt_r;
    static_nxt    = static_r;
    dt2_nxt       = dt2_r;
    term_nxt      = term_r;
    inc_nxt       = inc_r;
    rsum_nxt      = rsum_r;
    neg_nxt       = neg_r;
    sum_nxt       = sum_r;
    dist_nxt      = dist_r;
    delta_nxt     = delta_r;
    contact_nxt   = contact_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < 3; i++) begin
      cur_nxt[i]  = cur_r[i];
      prev_nxt[i] = prev_r[i];
      acc_nxt[i]  = acc_r[i];
      ad_nxt[i]   = ad_r[i];
      sh_nxt[i]   = sh_r[i];
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        vsb_pkg::CFG_RADIUS: radius_nxt = cfg_data;
        vsb_pkg::CFG_STEP:   dt_nxt     = cfg_data;
        vsb_pkg::CFG_STATIC: static_nxt = cfg_data[0];
        default:             static_nxt = static_r;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          ax_nxt      = '0;
          contact_nxt = 1'b0;
          for (int i = 0; i < 3; i++) sh_nxt[i] = '0;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = S_DONE;
        priority if (do_int) begin
          st_nxt = S_DT2;
        end else if (do_add) begin
          for (int i = 0; i < 3; i++) acc_nxt[i] = vsb_pkg::add_sat(acc_r[i], vec_r[i]);
        end else if (do_col) begin
          st_nxt = S_CDIFF;
        end else if (req_r == vsb_pkg::REQ_MOVE) begin
          for (int i = 0; i < 3; i++) begin
            cur_nxt[i]  = vsb_pkg::add_sat(cur_r[i], vec_r[i]);
            prev_nxt[i] = vsb_pkg::add_sat(prev_r[i], vec_r[i]);
          end
        end else if (req_r == vsb_pkg::REQ_SET_POS) begin
          for (int i = 0; i < 3; i++) cur_nxt[i] = vec_r[i];
        end else if (req_r == vsb_pkg::REQ_PLACE) begin
          for (int i = 0; i < 3; i++) begin
            cur_nxt[i]  = vec_r[i];
            prev_nxt[i] = vec_r[i];
          end
        end
      end
      S_DT2: begin
        if (mul_done) begin
          dt2_nxt = vsb_pkg::mulq_fix(mul_p, 1'b0);
          st_nxt  = S_ACCS;
        end
      end
      S_ACCS: st_nxt = S_ACCM;
      S_ACCM: begin
        if (mul_done) begin
          term_nxt = vsb_pkg::mulq_fix(mul_p, acc_ax[CW-1]);
          st_nxt   = S_VEL;
        end
      end
      S_VEL: begin
        inc_nxt = vsb_pkg::add_sat(vsb_pkg::sub_sat(cur_ax, prev_r[ax_r]), term_r);
        st_nxt  = S_UPD;
      end
      S_UPD: begin
        prev_nxt[ax_r] = cur_ax;
        cur_nxt[ax_r]  = vsb_pkg::add_sat(cur_ax, inc_r);
        acc_nxt[ax_r]  = '0;
        ax_nxt         = ax_r + 1'b1;
        st_nxt         = (ax_r == AX_LAST) ? S_DONE : S_ACCS;
      end
      S_CDIFF: begin
        rsum_nxt = rsum_w;
        sum_nxt  = '0;
        ax_nxt   = '0;
        for (int i = 0; i < 3; i++) begin
          ad_nxt[i]  = cad[i][CW-1:0];
          neg_nxt[i] = cd[i][CW];
        end
        st_nxt = far ? S_DONE : S_SQS;
      end
      S_SQS: st_nxt = S_SQ;
      S_SQ: begin
        if (mul_done) begin
          sum_nxt = sum_r + {2'b00, mul_p};
          ax_nxt  = (ax_r == AX_LAST) ? 2'd0 : ax_r + 1'b1;
          st_nxt  = (ax_r == AX_LAST) ? S_RSQS : S_SQS;
        end
      end
      S_RSQS: st_nxt = S_RSQ;
      S_RSQ: begin
        if (mul_done) begin
          // no overlap, or coincident centres: no correction
          st_nxt = ((sum_r >= {2'b00, mul_p}) || (sum_r == '0)) ? S_DONE : S_SQRTS;
        end
      end
      S_SQRTS: st_nxt = S_SQRT;
      S_SQRT: begin
        if (sqrt_done) begin
          dist_nxt  = sqrt_root;
          delta_nxt = rsum_r - sqrt_root;
          st_nxt    = S_CMS;
        end
      end
      S_CMS: st_nxt = S_CMUL;
      S_CMUL: begin
        if (mul_done) begin
          st_nxt = S_CDIV;
        end
      end
      S_CDIV: begin
        if (div_done) begin
          cur_nxt[ax_r] = vsb_pkg::add_sat(cur_ax, q_signed);
          sh_nxt[ax_r]  = ~q_signed + 1'b1;
          ax_nxt        = ax_r + 1'b1;
          if (ax_r == AX_LAST) begin
            contact_nxt = 1'b1;
            st_nxt      = S_DONE;
          end else begin
            st_nxt = S_CMS;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      radius_r    <= RW'(65536);
      dt_r        <= RW'(1092);
      static_r    <= 1'b0;
      contact_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur_r[i]  <= '0;
        prev_r[i] <= '0;
        acc_r[i]  <= '0;
        sh_r[i]   <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      radius_r    <= radius_nxt;
      dt_r        <= dt_nxt;
      static_r    <= static_nxt;
      contact_r   <= contact_nxt;
      for (int i = 0; i < 3; i++) begin
        cur_r[i]  <= cur_nxt[i];
        prev_r[i] <= prev_nxt[i];
        acc_r[i]  <= acc_nxt[i];
        sh_r[i]   <= sh_nxt[i];
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r    <= in_req_type;
      vec_r[0] <= in_vec_x;
      vec_r[1] <= in_vec_y;
      vec_r[2] <= in_vec_z;
      orad_r   <= in_other_radius;
    end
    dt2_r   <= dt2_nxt;
    term_r  <= term_nxt;
    inc_r   <= inc_nxt;
    rsum_r  <= rsum_nxt;
    neg_r   <= neg_nxt;
    sum_r   <= sum_nxt;
    dist_r  <= dist_nxt;
    delta_r <= delta_nxt;
    for (int i = 0; i < 3; i++) ad_r[i] <= ad_nxt[i];
    if (out_load) begin
      ocon_r <= contact_r;
      for (int i = 0; i < 3; i++) begin
        opos_r[i] <= cur_r[i];
        osh_r[i]  <= sh_r[i];
      end
    end
  end

  assign in_ready          = (st_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_pos_x         = opos_r[0];
  assign out_pos_y         = opos_r[1];
  assign out_pos_z         = opos_r[2];
  assign out_other_shift_x = osh_r[0];
  assign out_other_shift_y = osh_r[1];
  assign out_other_shift_z = osh_r[2];
  assign out_contact       = ocon_r;

  // a result without contact never carries a shift
  a_shift_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_contact) |->
      (out_other_shift_x == '0 && out_other_shift_y == '0 && out_other_shift_z == '0))
    else $error("shift reported without contact");

  // multiplier finishes only while the sequencer waits on it
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (st_r == S_DT2 || st_r == S_ACCM || st_r == S_SQ ||
                  st_r == S_RSQ || st_r == S_CMUL))
    else $error("multiplier result not consumed");

  a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (st_r == S_SQRT))
    else $error("root result not consumed");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == S_CDIV))
    else $error("divide result not consumed");

  // accepted word always goes straight to dispatch
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r == S_DISP))
    else $error("accepted word not dispatched");

endmodule
